// ===== hdl/dpcf_pkg.sv =====
// shared types and constants for the data point change filter
// no dependencies; imported by the controller and the datapath

package dpcf_pkg;

    localparam int ID_W    = 16;
    localparam int VALUE_W = 32;
    localparam int DB_W    = 16;

    // deadband after reset, about 0.001 in q16.16
    localparam logic [DB_W-1:0] DEADBAND_RESET = 16'd66;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_in;   // capture the accepted input transfer
        logic lookup;    // match the identifier against all slots
        logic read;      // read the cached value of the matching slot
        logic commit;    // decide, write back and load the result register
    } dpcf_cmd_t;

endpackage

// ===== hdl/dpcf_ctrl.sv =====
// controller state machine of the data point change filter
// depends on dpcf_pkg; drives dpcf_cmd_t commands into dpcf_datapath

module dpcf_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output dpcf_pkg::dpcf_cmd_t cmd
);
    import dpcf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_READ,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // wait until the result register is free
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/dpcf_datapath.sv =====
// datapath of the data point change filter: slot table, value memory,
// deadband register, difference and result register; depends on dpcf_pkg

module dpcf_datapath #(
    parameter int ENTRIES = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dpcf_pkg::dpcf_cmd_t           cmd,
    input  logic                          cfg_we,
    input  logic [dpcf_pkg::DB_W-1:0]     cfg_data,
    input  logic [dpcf_pkg::ID_W-1:0]     point_id,
    input  logic signed [dpcf_pkg::VALUE_W-1:0] sample_value,
    output logic                          changed,
    output logic                          was_new,
    output logic                          not_stored
);
    import dpcf_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [DB_W-1:0]    deadband_reg;
    logic [ENTRIES-1:0] slot_valid_reg;
    logic [ID_W-1:0]    slot_id_reg [ENTRIES];
    logic [VALUE_W-1:0] value_mem   [ENTRIES];

    logic [ID_W-1:0]    id_reg;
    logic [VALUE_W-1:0] val_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic               free_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [VALUE_W-1:0] old_val_reg;
    logic               changed_reg;
    logic               was_new_reg;
    logic               not_stored_reg;

    logic               hit_next;
    logic [IDX_W-1:0]   hit_idx_next;
    logic               free_next;
    logic [IDX_W-1:0]   free_idx_next;

    logic signed [VALUE_W:0] diff;
    logic [VALUE_W:0]        mag;
    logic                    below;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_addr;
    logic                    slot_we;

    // lowest matching valid slot and lowest free slot
    always_comb
    begin
        hit_next      = 1'b0;
        hit_idx_next  = '0;
        free_next     = 1'b0;
        free_idx_next = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (slot_valid_reg[i])
            begin
                if (!hit_next && slot_id_reg[i] == id_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = IDX_W'(i);
                end
            end
            else if (!free_next)
            begin
                free_next     = 1'b1;
                free_idx_next = IDX_W'(i);
            end
        end
    end

    // exact 33-bit difference and its magnitude
    assign diff  = $signed({old_val_reg[VALUE_W-1], old_val_reg})
                 - $signed({val_reg[VALUE_W-1], val_reg});
    assign mag   = diff[VALUE_W] ? (VALUE_W+1)'(-diff) : (VALUE_W+1)'(diff);
    assign below = mag < {{(VALUE_W+1-DB_W){1'b0}}, deadband_reg};

    assign mem_we   = cmd.commit && (hit_reg ? !below : free_reg);
    assign mem_addr = hit_reg ? hit_idx_reg : free_idx_reg;
    assign slot_we  = cmd.commit && !hit_reg && free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg   <= DEADBAND_RESET;
            slot_valid_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                deadband_reg <= cfg_data;
            end
            if (slot_we)
            begin
                slot_valid_reg[free_idx_reg] <= 1'b1;
            end
        end
    end

    // payload, lookup, read and result registers, slot identifiers and value memory
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            id_reg  <= point_id;
            val_reg <= sample_value;
        end
        if (cmd.lookup)
        begin
            hit_reg      <= hit_next;
            hit_idx_reg  <= hit_idx_next;
            free_reg     <= free_next;
            free_idx_reg <= free_idx_next;
        end
        if (cmd.read)
        begin
            old_val_reg <= value_mem[hit_idx_reg];
        end
        if (mem_we)
        begin
            value_mem[mem_addr] <= val_reg;
        end
        if (slot_we)
        begin
            slot_id_reg[free_idx_reg] <= id_reg;
        end
        if (cmd.commit)
        begin
            changed_reg    <= hit_reg ? !below : 1'b1;
            was_new_reg    <= !hit_reg;
            not_stored_reg <= !hit_reg && !free_reg;
        end
    end

    assign changed    = changed_reg;
    assign was_new    = was_new_reg;
    assign not_stored = not_stored_reg;

endmodule

// ===== hdl/data_point_change_filter_unit.sv =====
// sequence: after an input transfer is accepted the item passes the slot match,
//   the value memory read and the update, which waits while the result register
//   is still held by out_stall; the input stays stalled until the update is done
// reset: rst_n clears all slot valid marks, the deadband to 66, and the control
//   state; slot identifiers and values stay undefined until written
// top level of the data point change filter; depends on dpcf_pkg, dpcf_ctrl
//   and dpcf_datapath

module data_point_change_filter_unit #(
    parameter int ENTRIES = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel: one data point per transfer
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dpcf_pkg::ID_W-1:0]           point_id,
    input  logic signed [dpcf_pkg::VALUE_W-1:0] sample_value,
    // result channel: one result per data point
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                changed,
    output logic                                was_new,
    output logic                                not_stored,
    // deadband register write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dpcf_pkg::DB_W-1:0]           cfg_data
);
    import dpcf_pkg::*;

    dpcf_cmd_t cmd;

    // the deadband register takes a write at any cycle
    assign cfg_ready = 1'b1;

    // sequencer: idle, match, read, update; also owns the result valid flag
    dpcf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // slot table with parallel identifier match, value memory with a
    // registered read, deadband compare and result register
    dpcf_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .point_id     (point_id),
        .sample_value (sample_value),
        .changed      (changed),
        .was_new      (was_new),
        .not_stored   (not_stored)
    );

endmodule

// ===== hdl/dpcf_checker.sv =====
// port-level checks for data_point_change_filter_unit
// no dependencies; attached to the top level by the bind at the end

module dpcf_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic changed,
    input logic was_new,
    input logic not_stored
);

    // a point that was not stored must be a new one
    a_not_stored_new: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && not_stored |-> was_new)
        else $error("not_stored without was_new");

    // a new point always counts as changed
    a_new_changed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_new |-> changed)
        else $error("was_new without changed");

    // one item at a time: busy right after an input transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in work");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(changed) && $stable(was_new) && $stable(not_stored))
        else $error("stalled result changed");

endmodule

bind data_point_change_filter_unit dpcf_checker u_dpcf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .changed    (changed),
    .was_new    (was_new),
    .not_stored (not_stored)
);
